// File: design/gmt_pkg.sv
// gmt_pkg: shared widths, codes, reset values and record types of the
// gossip membership table; no dependencies, compiled first
`default_nettype none

package gmt_pkg;

   // table size and list limit
   localparam int GMT_TABLE_DEPTH = 32;
   localparam int MAX_OUT         = 32;

   // field widths
   localparam int ID_W       = 16;
   localparam int PORT_W     = 16;
   localparam int HB_W       = 32;
   localparam int TIME_W     = 32;
   localparam int TMO_W      = 16;
   localparam int PERIOD_W   = 8;
   localparam int FUNC_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_GOSSIP     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_JOIN_REQ   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_JOIN_REPLY = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_BOOT       = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_PORT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_INTRODUCER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOSSIP_PERIOD  = 3'd5;

   // register reset values
   localparam logic [ID_W-1:0]     SELF_ID_RESET        = 16'd1;
   localparam logic [PORT_W-1:0]   SELF_PORT_RESET      = 16'd0;
   localparam logic                IS_INTRODUCER_RESET  = 1'b0;
   localparam logic [TMO_W-1:0]    FAIL_TIMEOUT_RESET   = 16'd5;
   localparam logic [TMO_W-1:0]    REMOVE_TIMEOUT_RESET = 16'd20;
   localparam logic [PERIOD_W-1:0] GOSSIP_PERIOD_RESET  = 8'd1;

   // own heartbeat after reset
   localparam logic [HB_W-1:0] OWN_HB_RESET = 32'd5;

   // list kinds
   localparam logic LIST_FULL = 1'b0;
   localparam logic LIST_LIVE = 1'b1;

   // one stored table entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   heartbeat;
      logic [TIME_W-1:0] stamp;
   } gmt_entry_type;

   localparam int GMT_ENTRY_W = $bits(gmt_entry_type);

   // one emitted entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   heartbeat;
   } gmt_out_type;

   // remainder unit control and status
   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   dividend;
      logic [PERIOD_W-1:0] divisor;
   } gmt_mod_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] rem;
   } gmt_mod_sts_type;

endpackage

`default_nettype wire

// File: design/gmt_if.sv
// gmt_req_if / gmt_rsp_if: valid-ready channels of the membership table
// depends on gmt_pkg for the field widths
`default_nettype none

interface gmt_req_if import gmt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   member_id;
   logic [PORT_W-1:0] member_port;
   logic [HB_W-1:0]   member_heartbeat;

   modport source (output valid, func, member_id, member_port, member_heartbeat,
                   input ready);
   modport sink   (input valid, func, member_id, member_port, member_heartbeat,
                   output ready);
endinterface

interface gmt_rsp_if import gmt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              list_kind;
   logic [ID_W-1:0]   entry_id;
   logic [PORT_W-1:0] entry_port;
   logic [HB_W-1:0]   entry_heartbeat;
   logic              last;

   modport source (output valid, list_kind, entry_id, entry_port, entry_heartbeat, last,
                   input ready);
   modport sink   (input valid, list_kind, entry_id, entry_port, entry_heartbeat, last,
                   output ready);
endinterface

`default_nettype wire

// File: design/gmt_ram.sv
// gmt_ram: generic simple dual-port RAM, one write and one registered read
// depends on gmt_pkg for the default sizes
`default_nettype none

module gmt_ram import gmt_pkg::*; #(
   parameter int WIDTH = GMT_ENTRY_W,
   parameter int DEPTH = GMT_TABLE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/gmt_mod_unit.sv
// gmt_mod_unit: bit-serial remainder of the time counter by the gossip period
// depends on gmt_pkg for widths and the control/status records
`default_nettype none

module gmt_mod_unit import gmt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire gmt_mod_req_type mod_req,
   output      gmt_mod_sts_type mod_sts
);

   localparam int STEP_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] div_ff, div_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[TIME_W-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_sts.busy = busy_ff;
   assign mod_sts.done = done_ff;
   assign mod_sts.rem  = rem_ff;

endmodule

`default_nettype wire

// File: design/gossip_membership_table_top.sv
// gossip_membership_table_top: membership table sequencer, table RAM and
// remainder unit; depends on gmt_pkg, gmt_if, gmt_ram and gmt_mod_unit
//
// The block holds up to TABLE_DEPTH members (id, port, heartbeat, stamp) in one
// RAM with a registered read port, walked by a small sequencer that looks at one
// entry per cycle, except while the result channel stalls a list, through a
// single age subtract-and-compare unit. Per request: join reply, tick outside
// the group, boot by a non-introducer and unknown codes end on acceptance; a boot
// by the introducer appends its own node; a gossip entry scans the table and
// appends when its id is not found; a join request appends the member, then
// emits the full list, holding while the result channel stalls; a tick inside
// the group first waits for the serial remainder of the time by the gossip
// period, then on a gossip tick runs the removal pass and emits the live list.
// Requests are taken only while the sequencer is idle; a finished list drains
// from the output register while the next request is being taken. The table is
// not cleared after reset: only entries below the entry count are ever read. A
// list carries at most 32 entries.
`default_nettype none

module gossip_membership_table_top import gmt_pkg::*; #(
   parameter int TABLE_DEPTH = GMT_TABLE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gmt_req_if.sink                    req_chan,
   gmt_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int N_W   = $clog2(MAX_OUT + 1);

   typedef enum logic [8:0] {
      ST_IDLE        = 9'b000000001,
      ST_SCAN        = 9'b000000010,
      ST_APPEND      = 9'b000000100,
      ST_MOD         = 9'b000001000,
      ST_COMPACT     = 9'b000010000,
      ST_COMPACT_END = 9'b000100000,
      ST_EMIT_START  = 9'b001000000,
      ST_EMIT        = 9'b010000000,
      ST_EMIT_END    = 9'b100000000
   } gmt_state_type;

   gmt_state_type state_ff, state_in;

   // configuration registers
   logic [ID_W-1:0]     self_id_ff, self_id_in;
   logic [PORT_W-1:0]   self_port_ff, self_port_in;
   logic                intro_ff, intro_in;
   logic [TMO_W-1:0]    fail_tmo_ff, fail_tmo_in;
   logic [TMO_W-1:0]    remove_tmo_ff, remove_tmo_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   // node state
   logic [CNT_W-1:0]    entry_count_ff, entry_count_in;
   logic [HB_W-1:0]     own_hb_ff, own_hb_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                in_group_ff, in_group_in;

   // request held during its work
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ID_W-1:0]     rq_id_ff, rq_id_in;
   logic [PORT_W-1:0]   rq_port_ff, rq_port_in;
   logic [HB_W-1:0]     rq_hb_ff, rq_hb_in;

   // walk control
   logic [AW-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic                seen_ff, seen_in;
   logic                found_ff, found_in;
   logic                live_ff, live_in;
   logic [N_W-1:0]      emit_n_ff, emit_n_in;
   logic                pend_valid_ff, pend_valid_in;
   gmt_out_type         pend_ff, pend_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   gmt_out_type         rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // datapath signals
   logic                req_acc;
   logic                slot_free;
   logic                emit_load;
   logic                emit_last;
   logic                id_match;
   logic                self_match;
   logic                idx_at_end;
   logic                take;
   logic [CNT_W-1:0]    idx_nxt_cnt;
   logic [TIME_W-1:0]   age;
   logic                too_old_rm;
   logic                too_old_fail;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   gmt_entry_type       wr_data;
   gmt_entry_type       rd_entry;
   gmt_entry_type       app_entry;
   gmt_mod_req_type     mod_req;
   gmt_mod_sts_type     mod_sts;

   // member table storage
   gmt_ram #(
      .WIDTH (GMT_ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_entry)
   );

   // serial remainder for the gossip tick test
   gmt_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_sts (mod_sts)
   );

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // shared age unit and entry compares
   assign age          = time_ff - rd_entry.stamp;
   assign too_old_rm   = age > TIME_W'(remove_tmo_ff);
   assign too_old_fail = age > TIME_W'(fail_tmo_ff);
   assign id_match     = (rd_entry.id == rq_id_ff);
   assign self_match   = (rd_entry.id == self_id_ff) && (rd_entry.port == self_port_ff);
   assign idx_nxt_cnt  = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_at_end   = (idx_nxt_cnt == entry_count_ff);
   assign take         = (live_ff == LIST_FULL) || !too_old_fail;

   // entry to append: own node on boot, the requested member otherwise
   always_comb begin
      if (func_ff == FUNC_BOOT) begin
         app_entry.id        = self_id_ff;
         app_entry.port      = self_port_ff;
         app_entry.heartbeat = own_hb_ff;
      end else begin
         app_entry.id        = rq_id_ff;
         app_entry.port      = rq_port_ff;
         app_entry.heartbeat = rq_hb_ff;
      end
      app_entry.stamp = time_ff;
   end

   // configuration writes
   always_comb begin
      self_id_in    = self_id_ff;
      self_port_in  = self_port_ff;
      intro_in      = intro_ff;
      fail_tmo_in   = fail_tmo_ff;
      remove_tmo_in = remove_tmo_ff;
      period_in     = period_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SELF_ID:        self_id_in    = csr_wr_data[ID_W-1:0];
            CSR_SELF_PORT:      self_port_in  = csr_wr_data[PORT_W-1:0];
            CSR_IS_INTRODUCER:  intro_in      = csr_wr_data[0];
            CSR_FAIL_TIMEOUT:   fail_tmo_in   = csr_wr_data[TMO_W-1:0];
            CSR_REMOVE_TIMEOUT: remove_tmo_in = csr_wr_data[TMO_W-1:0];
            CSR_GOSSIP_PERIOD:  period_in     = csr_wr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      own_hb_in      = own_hb_ff;
      time_in        = time_ff;
      in_group_in    = in_group_ff;
      func_in        = func_ff;
      rq_id_in       = rq_id_ff;
      rq_port_in     = rq_port_ff;
      rq_hb_in       = rq_hb_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      seen_in        = seen_ff;
      found_in       = found_ff;
      live_in        = live_ff;
      emit_n_in      = emit_n_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      emit_load      = 1'b0;
      emit_last      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = rd_entry;
      mod_req.start    = 1'b0;
      mod_req.dividend = time_ff + TIME_W'(1);
      mod_req.divisor  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               func_in    = req_chan.func;
               rq_id_in   = req_chan.member_id;
               rq_port_in = req_chan.member_port;
               rq_hb_in   = req_chan.member_heartbeat;
               idx_in     = '0;
               k_in       = '0;
               seen_in    = 1'b0;
               found_in   = 1'b0;
               case (req_chan.func)
                  FUNC_GOSSIP: begin
                     state_in = (entry_count_ff == '0) ? ST_APPEND : ST_SCAN;
                  end
                  FUNC_JOIN_REQ: begin
                     live_in  = LIST_FULL;
                     state_in = ST_APPEND;
                  end
                  FUNC_JOIN_REPLY: begin
                     in_group_in = 1'b1;
                  end
                  FUNC_TICK: begin
                     time_in = time_ff + TIME_W'(1);
                     if (in_group_ff) begin
                        mod_req.start = 1'b1;
                        state_in      = ST_MOD;
                     end
                  end
                  FUNC_BOOT: begin
                     if (intro_ff) begin
                        in_group_in = 1'b1;
                        state_in    = ST_APPEND;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // raise heartbeats of every entry with the gossiped id
         ST_SCAN: begin
            if (id_match) begin
               seen_in = 1'b1;
               if (rd_entry.heartbeat < rq_hb_ff) begin
                  wr_en             = 1'b1;
                  wr_data.heartbeat = rq_hb_ff;
                  wr_data.stamp     = time_ff;
               end
            end
            idx_in = idx_ff + AW'(1);
            if (idx_at_end) begin
               state_in = (seen_ff || id_match) ? ST_IDLE : ST_APPEND;
            end
         end

         // append unless the table is full
         ST_APPEND: begin
            if (entry_count_ff < CNT_W'(TABLE_DEPTH)) begin
               wr_en          = 1'b1;
               wr_addr        = entry_count_ff[AW-1:0];
               wr_data        = app_entry;
               entry_count_in = entry_count_ff + CNT_W'(1);
            end
            state_in = (func_ff == FUNC_JOIN_REQ) ? ST_EMIT_START : ST_IDLE;
         end

         // wait for time modulo period
         ST_MOD: begin
            if (mod_sts.done) begin
               if (mod_sts.rem == '0 && entry_count_ff != '0) begin
                  idx_in   = '0;
                  k_in     = '0;
                  state_in = ST_COMPACT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // drop expired entries, refresh the first own entry on the way
         ST_COMPACT: begin
            if (!too_old_rm) begin
               wr_en   = 1'b1;
               wr_addr = k_ff[AW-1:0];
               if (!found_ff && self_match) begin
                  wr_data.heartbeat = own_hb_ff + HB_W'(1);
                  wr_data.stamp     = time_ff;
                  own_hb_in         = own_hb_ff + HB_W'(1);
                  found_in          = 1'b1;
               end
               k_in = k_ff + CNT_W'(1);
            end
            idx_in = idx_ff + AW'(1);
            if (idx_at_end) begin
               state_in = ST_COMPACT_END;
            end
         end

         ST_COMPACT_END: begin
            entry_count_in = k_ff;
            live_in        = LIST_LIVE;
            state_in       = (found_ff && k_ff >= CNT_W'(2)) ? ST_EMIT_START : ST_IDLE;
         end

         ST_EMIT_START: begin
            idx_in        = '0;
            emit_n_in     = '0;
            pend_valid_in = 1'b0;
            state_in      = ST_EMIT;
         end

         // one entry held back so the final one can carry last
         ST_EMIT: begin
            if (take && pend_valid_ff && !slot_free) begin
               idx_in = idx_ff;
            end else begin
               if (take) begin
                  emit_load         = pend_valid_ff;
                  pend_in.id        = rd_entry.id;
                  pend_in.port      = rd_entry.port;
                  pend_in.heartbeat = rd_entry.heartbeat;
                  pend_valid_in     = 1'b1;
                  emit_n_in         = emit_n_ff + N_W'(1);
               end
               idx_in = idx_ff + AW'(1);
               if (idx_at_end || (take && (emit_n_ff + N_W'(1)) == N_W'(MAX_OUT))) begin
                  state_in = ST_EMIT_END;
               end
            end
         end

         ST_EMIT_END: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               emit_load     = 1'b1;
               emit_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = live_ff;
         rsp_data_in  = pend_ff;
         rsp_last_in  = emit_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         self_id_ff     <= SELF_ID_RESET;
         self_port_ff   <= SELF_PORT_RESET;
         intro_ff       <= IS_INTRODUCER_RESET;
         fail_tmo_ff    <= FAIL_TIMEOUT_RESET;
         remove_tmo_ff  <= REMOVE_TIMEOUT_RESET;
         period_ff      <= GOSSIP_PERIOD_RESET;
         entry_count_ff <= '0;
         own_hb_ff      <= OWN_HB_RESET;
         time_ff        <= '0;
         in_group_ff    <= 1'b0;
         idx_ff         <= '0;
         k_ff           <= '0;
         seen_ff        <= 1'b0;
         found_ff       <= 1'b0;
         live_ff        <= LIST_FULL;
         emit_n_ff      <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         self_id_ff     <= self_id_in;
         self_port_ff   <= self_port_in;
         intro_ff       <= intro_in;
         fail_tmo_ff    <= fail_tmo_in;
         remove_tmo_ff  <= remove_tmo_in;
         period_ff      <= period_in;
         entry_count_ff <= entry_count_in;
         own_hb_ff      <= own_hb_in;
         time_ff        <= time_in;
         in_group_ff    <= in_group_in;
         idx_ff         <= idx_in;
         k_ff           <= k_in;
         seen_ff        <= seen_in;
         found_ff       <= found_in;
         live_ff        <= live_in;
         emit_n_ff      <= emit_n_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      rq_id_ff    <= rq_id_in;
      rq_port_ff  <= rq_port_in;
      rq_hb_ff    <= rq_hb_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.list_kind       = rsp_kind_ff;
   assign rsp_chan.entry_id        = rsp_data_ff.id;
   assign rsp_chan.entry_port      = rsp_data_ff.port;
   assign rsp_chan.entry_heartbeat = rsp_data_ff.heartbeat;
   assign rsp_chan.last            = rsp_last_ff;

   // table never grows past its depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // removal pass never writes ahead of its read pointer
   a_compact_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPACT) |-> (k_ff <= CNT_W'(idx_ff)))
      else $error("compaction write index ahead of read index");

   // remainder result only arrives while the sequencer waits for it
   a_mod_done_wait : assert property (@(posedge clock) disable iff (reset)
      mod_sts.done |-> (state_ff == ST_MOD))
      else $error("remainder done outside wait state");

   // a held-back entry exists only during list emission
   a_pend_emit : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_EMIT || state_ff == ST_EMIT_END))
      else $error("pending list entry outside emission");

endmodule

`default_nettype wire

// File: bench/gossip_membership_table_top_tb.sv
// gossip_membership_table_top_tb: self-checking bench for the gossip membership table
// drives the request channel and the register port, predicts every emitted entry
// depends on gmt_pkg, gmt_if and gossip_membership_table_top
`timescale 1ns / 100ps

module gossip_membership_table_top_tb;
   import gmt_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_LAST_CODE = '1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 160;

   // one emitted table entry as seen on the result channel
   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   heartbeat;
      logic              last;
   } listed_entry_type;

   // membership predictor and store of expected list entries
   class gmt_scoreboard;
      logic [ID_W-1:0]     self_id;
      logic [PORT_W-1:0]   self_port;
      logic                is_introducer;
      logic [TMO_W-1:0]    fail_timeout;
      logic [TMO_W-1:0]    remove_timeout;
      logic [PERIOD_W-1:0] gossip_period;
      gmt_entry_type       members [GMT_TABLE_DEPTH];
      int unsigned         member_count;
      logic [HB_W-1:0]     own_heartbeat;
      logic [TIME_W-1:0]   now_ticks;
      logic                in_group;
      listed_entry_type    listed_q [$];
      int                  errors;

      function new();
         self_id        = SELF_ID_RESET;
         self_port      = SELF_PORT_RESET;
         is_introducer  = IS_INTRODUCER_RESET;
         fail_timeout   = FAIL_TIMEOUT_RESET;
         remove_timeout = REMOVE_TIMEOUT_RESET;
         gossip_period  = GOSSIP_PERIOD_RESET;
         member_count   = 0;
         own_heartbeat  = OWN_HB_RESET;
         now_ticks      = '0;
         in_group       = 1'b0;
         errors         = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_SELF_ID:        self_id        = val[ID_W-1:0];
            CSR_SELF_PORT:      self_port      = val[PORT_W-1:0];
            CSR_IS_INTRODUCER:  is_introducer  = val[0];
            CSR_FAIL_TIMEOUT:   fail_timeout   = val[TMO_W-1:0];
            CSR_REMOVE_TIMEOUT: remove_timeout = val[TMO_W-1:0];
            CSR_GOSSIP_PERIOD:  gossip_period  = val[PERIOD_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TIME_W-1:0] age_of(int unsigned i);
         return now_ticks - members[i].stamp;
      endfunction

      // appends to a full table are dropped
      function void add_member(logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                               logic [HB_W-1:0] hb);
         if (member_count >= GMT_TABLE_DEPTH) return;
         members[member_count].id        = id;
         members[member_count].port      = port;
         members[member_count].heartbeat = hb;
         members[member_count].stamp     = now_ticks;
         member_count++;
      endfunction

      // queue a list in table order, last flag on its final entry
      function void list_members(logic kind, bit live_only);
         listed_entry_type batch [$];
         listed_entry_type e;
         for (int unsigned i = 0; i < member_count && batch.size() < MAX_OUT; i++) begin
            if (live_only && age_of(i) > {16'd0, fail_timeout}) continue;
            e.kind      = kind;
            e.id        = members[i].id;
            e.port      = members[i].port;
            e.heartbeat = members[i].heartbeat;
            e.last      = 1'b0;
            batch.push_back(e);
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[j]) listed_q.push_back(batch[j]);
      endfunction

      // drop expired members, refresh own entry, gossip the live ones
      function void gossip_round();
         int unsigned k;
         int          pos;
         k   = 0;
         pos = -1;
         for (int unsigned i = 0; i < member_count; i++) begin
            if (age_of(i) > {16'd0, remove_timeout}) continue;
            members[k] = members[i];
            k++;
         end
         member_count = k;
         for (int unsigned i = 0; i < member_count; i++) begin
            if (pos < 0 && members[i].id == self_id && members[i].port == self_port)
               pos = i;
         end
         if (pos < 0) return;
         own_heartbeat           = own_heartbeat + 1;
         members[pos].heartbeat  = own_heartbeat;
         members[pos].stamp      = now_ticks;
         if (member_count < 2) return;
         list_members(LIST_LIVE, 1'b1);
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                 logic [PORT_W-1:0] port, logic [HB_W-1:0] hb);
         bit                  seen;
         logic [PERIOD_W-1:0] period;
         seen = 1'b0;
         case (func)
            FUNC_GOSSIP: begin
               for (int unsigned i = 0; i < member_count; i++) begin
                  if (members[i].id == id) begin
                     if (members[i].heartbeat < hb) begin
                        members[i].heartbeat = hb;
                        members[i].stamp     = now_ticks;
                     end
                     seen = 1'b1;
                  end
               end
               if (!seen) add_member(id, port, hb);
            end
            FUNC_JOIN_REQ: begin
               add_member(id, port, hb);
               list_members(LIST_FULL, 1'b0);
            end
            FUNC_JOIN_REPLY: in_group = 1'b1;
            FUNC_TICK: begin
               now_ticks = now_ticks + 1;
               // a zero period counts as one
               period = (gossip_period == 0) ? 8'd1 : gossip_period;
               if (in_group && (now_ticks % {24'd0, period}) == 0) gossip_round();
            end
            FUNC_BOOT: begin
               if (is_introducer) begin
                  in_group = 1'b1;
                  add_member(self_id, self_port, own_heartbeat);
               end
            end
            default: ;
         endcase
      endfunction

      function int pending();
         return listed_q.size();
      endfunction

      task report(string msg);
         if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_entry(listed_entry_type got);
         listed_entry_type want;
         if (listed_q.size() == 0) begin
            report($sformatf("unexpected entry id %h port %h", got.id, got.port));
            return;
         end
         want = listed_q.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("list_kind %b, expected %b", got.kind, want.kind));
         if (got.id !== want.id)
            report($sformatf("entry_id %h, expected %h", got.id, want.id));
         if (got.port !== want.port)
            report($sformatf("entry_port %h, expected %h", got.port, want.port));
         if (got.heartbeat !== want.heartbeat)
            report($sformatf("entry_heartbeat %h, expected %h", got.heartbeat,
                             want.heartbeat));
         if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   int                    gap_calm = 0;
   int                    stall_calm = 0;
   int                    idle_cycles = 0;
   gmt_scoreboard         sb = new();

   gmt_req_if req_bus ();
   gmt_rsp_if rsp_bus ();

   gossip_membership_table_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // wait draw: stretches of back-to-back items, otherwise a random wait
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(4, 16);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // present one request and hold it until taken
   task send(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
             logic [HB_W-1:0] hb);
      int gap;
      gap = draw_wait(gap_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.func             <= func;
      req_bus.member_id        <= id;
      req_bus.member_port      <= port;
      req_bus.member_heartbeat <= hb;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop sending until every expected entry is out
   task drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // drained and then idle long enough for a silent request to finish
   task settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task apply_settings(logic [ID_W-1:0] id, logic [PORT_W-1:0] port, logic intro,
                       logic [TMO_W-1:0] fail_tmo, logic [TMO_W-1:0] remove_tmo,
                       logic [PERIOD_W-1:0] period);
      logic [CSR_DATA_W-1:0] vals [6];
      logic [CSR_IDX_W-1:0]  idxs [6];
      idxs = '{CSR_SELF_ID, CSR_SELF_PORT, CSR_IS_INTRODUCER, CSR_FAIL_TIMEOUT,
               CSR_REMOVE_TIMEOUT, CSR_GOSSIP_PERIOD};
      vals = '{id, port, {15'd0, intro}, fail_tmo, remove_tmo, {8'd0, period}};
      foreach (idxs[i]) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idxs[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
         sb.set_reg(idxs[i], vals[i]);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [FUNC_W-1:0] FUNC_FIELD(int unsigned code);
      return code[FUNC_W-1:0];
   endfunction

   // one random request, mostly gossip and ticks over a small id pool
   task random_request(logic [ID_W-1:0] id_base);
      int unsigned       pick;
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   hb;
      pick = $urandom_range(0, 99);
      id   = (pick % 10 == 0) ? ID_W'($urandom) : id_base + ID_W'($urandom_range(0, 47));
      port = PORT_W'($urandom);
      hb   = $urandom;
      if (pick < 40)      send(FUNC_GOSSIP, id, port, hb);
      else if (pick < 47) send(FUNC_GOSSIP, sb.self_id, sb.self_port, hb);
      else if (pick < 75) send(FUNC_TICK, id, port, hb);
      else if (pick < 85) send(FUNC_JOIN_REQ, id, port, hb);
      else if (pick < 90) send(FUNC_BOOT, id, port, hb);
      else if (pick < 94) send(FUNC_JOIN_REPLY, id, port, hb);
      else send(FUNC_FIELD(($urandom_range(FUNC_BOOT + 1, FUNC_LAST_CODE))), id, port, hb);
   endtask

   // random run with one full pause halfway through
   task random_run(int items, logic [ID_W-1:0] id_base);
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) drain();
         random_request(id_base);
      end
   endtask

   // result side: random stalls before each entry
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         stall = draw_wait(stall_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // monitor: check entries first, then note the request taken at the same edge
   initial begin
      listed_entry_type got;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               got.kind      = rsp_bus.list_kind;
               got.id        = rsp_bus.entry_id;
               got.port      = rsp_bus.entry_port;
               got.heartbeat = rsp_bus.entry_heartbeat;
               got.last      = rsp_bus.last;
               sb.check_entry(got);
            end
            if (req_bus.valid && req_bus.ready)
               sb.note_request(req_bus.func, req_bus.member_id, req_bus.member_port,
                               req_bus.member_heartbeat);
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid            <= 1'b0;
      req_bus.func             <= FUNC_GOSSIP;
      req_bus.member_id        <= '0;
      req_bus.member_port      <= '0;
      req_bus.member_heartbeat <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: outside the group, then join and gossip
      send(FUNC_TICK, '0, '0, '0);
      send(FUNC_BOOT, '1, '1, '1);
      send(FUNC_GOSSIP, 16'h0000, 16'h0000, 32'h0000_0000);
      send(FUNC_GOSSIP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send(FUNC_GOSSIP, 16'h0000, 16'h1357, 32'h0000_0010);
      send(FUNC_GOSSIP, 16'hFFFF, 16'h0001, 32'h0000_0005);
      send(FUNC_JOIN_REQ, SELF_ID_RESET, SELF_PORT_RESET, 32'h0000_0003);
      send(FUNC_FIELD(FUNC_BOOT + 1), 16'hAAAA, 16'h5555, 32'hDEAD_BEEF);
      send(FUNC_FIELD(FUNC_BOOT + 2), 16'h5555, 16'hAAAA, 32'h1234_5678);
      send(FUNC_LAST_CODE, '1, '1, '1);
      send(FUNC_JOIN_REPLY, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0);
      send(FUNC_TICK, '1, '1, '1);
      send(FUNC_TICK, '0, '0, '0);
      settle();

      // introducer, timeouts of one, zero period
      apply_settings(16'hFFFF, 16'hFFFF, 1'b1, 16'd1, 16'd1, 8'd0);
      send(FUNC_BOOT, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0);
      send(FUNC_TICK, '0, '0, '0);
      send(FUNC_GOSSIP, 16'h1234, 16'h5678, 32'h8000_0001);
      send(FUNC_TICK, '0, '0, '0);
      send(FUNC_JOIN_REQ, 16'h4321, 16'h8765, 32'h7FFF_FFFE);
      settle();

      apply_settings(16'd7, 16'h1234, 1'b1, 16'd3, 16'd8, 8'd2);
      send(FUNC_BOOT, '0, '0, '0);
      random_run(25, 16'h0100);
      settle();

      // widest timeouts: the table fills up and appends get dropped
      apply_settings(16'd0, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF, 8'd1);
      random_run(40, 16'h2000);
      settle();

      // longest period: remainders of the time stay away from zero
      apply_settings(16'hA5A5, 16'h5A5A, 1'b1, 16'd100, 16'd300, 8'd255);
      send(FUNC_BOOT, '0, '0, '0);
      repeat (3) send(FUNC_GOSSIP, ID_W'($urandom), PORT_W'($urandom), $urandom);
      repeat (3) send(FUNC_TICK, '0, '0, '0);
      send(FUNC_GOSSIP, ID_W'($urandom), PORT_W'($urandom), $urandom);
      send(FUNC_TICK, '0, '0, '0);
      random_run(10, 16'hC000);
      settle();

      apply_settings(16'd3, 16'd3, 1'b0, 16'd2, 16'd4, 8'd3);
      random_run(20, 16'h0000);
      settle();

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
